// ===== hw/rtl/suvt_pkg.sv =====
package suvt_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned TolW     = 31;
  localparam int unsigned RdIdxW   = 6;
  localparam int unsigned SlotW    = 7;
  localparam int unsigned SelW     = (CntW > RdIdxW) ? CntW : RdIdxW;
  localparam logic [TolW-1:0] TolReset = TolW'(7);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_READ_OK   = 3'd3,
    STAT_READ_OOR  = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic              capture;
    logic              insert;
    logic [DataW-1:0]  cmp_value;
    logic [DataW-1:0]  ins_value;
    logic [TolW-1:0]   tolerance;
  } cell_ctrl_t;

  // lowest set position, Capacity when none
  function automatic logic [CntW-1:0] first_set(logic [Capacity-1:0] vec);
    logic [CntW-1:0] r;
    r = CntW'(Capacity);
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (vec[i]) begin
        r = CntW'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/suvt_cell.sv =====
module suvt_cell (
  input  logic                             clk_i,
  input  suvt_pkg::cell_ctrl_t             ctrl_i,
  input  logic                             valid_i,
  input  logic                             prev_le_i,
  input  logic [suvt_pkg::DataW-1:0]       prev_value_i,
  output logic [suvt_pkg::DataW-1:0]       value_o,
  output logic                             le_o,
  output logic                             match_o
);
  import suvt_pkg::*;

  logic [DataW-1:0]  value_q, value_d;
  logic              le_q, match_q;
  logic signed [DataW:0] diff;
  logic [DataW:0]    abs_diff;
  logic              near, le_now;

  always_comb begin
    diff     = $signed({ctrl_i.cmp_value[DataW-1], ctrl_i.cmp_value})
             - $signed({value_q[DataW-1], value_q});
    abs_diff = diff[DataW] ? (DataW+1)'(-diff) : (DataW+1)'(diff);
    near     = abs_diff <= {2'b00, ctrl_i.tolerance};
    le_now   = $signed(value_q) <= $signed(ctrl_i.cmp_value);
  end

  // entries at or below the new value stay; the first larger one takes it
  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert && !le_q) begin
      value_d = prev_le_i ? ctrl_i.ins_value : prev_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (ctrl_i.capture) begin
      le_q    <= valid_i & le_now;
      match_q <= valid_i & near;
    end
  end

  assign value_o = value_q;
  assign le_o    = le_q;
  assign match_o = match_q;

endmodule

// ===== hw/rtl/sorted_unique_value_table_unit.sv =====
// Sorted table of distinct signed Q16.16 values with a match tolerance.
// Input stream: s_axis_tuser carries the operation (insert, read, clear),
// s_axis_tdata the value to insert and the index to read. One result item
// per input item leaves on the m_axis stream: status in tuser, slot, entry
// count and read data in tdata.
// Each table entry lives in a cell of a row; all cells compare the value
// at once and an insert shifts all the larger entries up one cell together.
// The cells compare the value and register their flags as an item is
// accepted; then the shift is committed and the output register loaded.
// The block takes no new item until that commit is done.
// The output register holds the result while m_axis_tready is low; the next
// item is still accepted and evaluated, and its commit waits until the
// output register frees up.
// cfg_we_i/cfg_wdata_i write the match tolerance; write only while idle.
// Reset empties the table, sets the tolerance to 7 and drops any result.
module sorted_unique_value_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sample_value[31:0], read_index[37:32]
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // slot[6:0], entry_count[13:7], read_data[45:14]
  output logic [2:0]  m_axis_tuser,   // status
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i     // match_tolerance
);
  import suvt_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [TolW-1:0]   tol_q;
  func_e             op_q;
  logic [DataW-1:0]  val_q;
  logic [RdIdxW-1:0] idx_q;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [SlotW-1:0]  out_slot_q, out_slot_d;
  logic [SlotW-1:0]  out_count_q, out_count_d;
  logic [DataW-1:0]  out_data_q, out_data_d;

  logic              accept, out_free, commit, do_insert;
  cell_ctrl_t        ctrl;
  logic [Capacity-1:0] le_vec, match_vec, cell_valid;
  logic [DataW-1:0]  cell_val [Capacity];
  logic [CntW-1:0]   pos, match_idx;
  logic              dup, read_ok;
  logic [DataW-1:0]  read_val;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign commit        = (state_q == ST_EVAL) && out_free;

  assign ctrl.capture   = accept;
  assign ctrl.insert    = do_insert;
  assign ctrl.cmp_value = s_axis_tdata[DataW-1:0];
  assign ctrl.ins_value = val_q;
  assign ctrl.tolerance = tol_q;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic             prev_le;
    logic [DataW-1:0] prev_val;
    if (i == 0) begin : g_head
      assign prev_le  = 1'b1;
      assign prev_val = val_q;
    end else begin : g_body
      assign prev_le  = le_vec[i-1];
      assign prev_val = cell_val[i-1];
    end
    assign cell_valid[i] = CntW'(i) < count_q;
    suvt_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (cell_valid[i]),
      .prev_le_i    (prev_le),
      .prev_value_i (prev_val),
      .value_o      (cell_val[i]),
      .le_o         (le_vec[i]),
      .match_o      (match_vec[i])
    );
  end

  always_comb begin
    read_val = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (SelW'(i) == SelW'(idx_q)) begin
        read_val = read_val | cell_val[i];
      end
    end
  end

  assign pos       = first_set(~le_vec);
  assign match_idx = first_set(match_vec);
  assign dup       = |match_vec;
  assign read_ok   = SelW'(idx_q) < SelW'(count_q);
  assign do_insert = commit && (op_q == FUNC_INSERT) && !dup
                     && (count_q < CntW'(Capacity));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d      = count_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;
    out_data_d   = out_data_q;
    if (commit) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      priority if (op_q == FUNC_INSERT) begin
        if (dup) begin
          out_status_d = STAT_DUPLICATE;
          out_slot_d   = SlotW'(match_idx);
        end else if (!do_insert) begin
          out_status_d = STAT_FULL;
          out_slot_d   = SlotW'(pos);
        end else begin
          out_status_d = STAT_INSERTED;
          out_slot_d   = SlotW'(pos);
          count_d      = count_q + CntW'(1);
        end
      end else if (op_q == FUNC_READ) begin
        out_slot_d = SlotW'(idx_q);
        if (read_ok) begin
          out_status_d = STAT_READ_OK;
          out_data_d   = read_val;
        end else begin
          out_status_d = STAT_READ_OOR;
        end
      end else begin
        out_status_d = STAT_CLEARED;
        out_slot_d   = '0;
        count_d      = '0;
      end
      out_count_d = SlotW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      tol_q       <= TolReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= (s_axis_tuser[1]) ? FUNC_CLEAR : func_e'(s_axis_tuser);
      val_q <= s_axis_tdata[DataW-1:0];
      idx_q <= s_axis_tdata[DataW+RdIdxW-1:DataW];
    end
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_count_q  <= out_count_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {2'b00, out_data_q, out_count_q, out_slot_q};

  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_no_dup_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |-> !dup && (pos <= count_q))
    else $error("insert of a matching value or past the end");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + CntW'(1))
    else $error("count did not step on insert");

  a_sorted_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> ((le_vec & (le_vec + Capacity'(1))) == '0))
    else $error("compare flags not contiguous, table out of order");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> !$past(commit))
    else $error("result committed over a held result");

endmodule
